// ----- hw/rtl/cd_sector_track_locator_unit_assert.svh -----
// Assertion macros for the sector track locator unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CD_SECTOR_TRACK_LOCATOR_UNIT_ASSERT_SVH
`define CD_SECTOR_TRACK_LOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CSTL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion lbl failed");
`define CSTL_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion lbl failed");
`else
`define CSTL_ASSERT(lbl, prop)
`define CSTL_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/cstl_pkg.sv -----
// Types, constants and helpers shared by the sector track locator unit.
// No dependencies.
package cstl_pkg;

  localparam int unsigned MaxEntries = 128;
  localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CountW     = 8;
  localparam int unsigned EntryIdxW  = 7;
  localparam int unsigned FrameW     = 19;
  localparam int unsigned SkipW      = 32;
  localparam int unsigned SizeW      = 2;
  localparam int unsigned TrackW     = 7;
  localparam int unsigned LenW       = 12;
  localparam int unsigned MinW       = 7;
  localparam int unsigned SecW       = 6;
  localparam int unsigned FrmW       = 7;
  localparam int unsigned MsfW       = 20;
  localparam int unsigned QuotW      = 13;
  localparam int unsigned ProdW      = FrameW + LenW;
  localparam int unsigned SumW       = SkipW + 1;

  typedef enum logic [0:0] {
    ActWrite  = 1'b0,
    ActLookup = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoTrack = 2'd1,
    StRawErr  = 2'd2
  } status_e;

  localparam logic [SizeW-1:0] SizeCooked = 2'd0;
  localparam logic [SizeW-1:0] SizeMode2  = 2'd1;
  localparam logic [SizeW-1:0] SizeRaw    = 2'd2;

  localparam logic [LenW-1:0] CookedBytes = 12'd2048;
  localparam logic [LenW-1:0] Mode2Bytes  = 12'd2336;
  localparam logic [LenW-1:0] RawBytes    = 12'd2352;

  localparam logic [MsfW-1:0] MsfLead    = 20'd150;
  localparam logic [SumW-1:0] AdjMode1   = 33'd16;
  localparam logic [SumW-1:0] AdjMode2   = 33'd24;

  // floor(x/75) = (x * Recip75) >> 26 for x < 2^20
  localparam logic [MsfW-1:0]  Recip75   = 20'd894785;
  localparam int unsigned      Recip75Sh = 26;
  // floor(q/60) = (q * Recip60) >> 19 for q < 2^13
  localparam logic [QuotW:0]   Recip60   = 14'd8739;
  localparam int unsigned      Recip60Sh = 19;

  typedef struct packed {
    logic [FrameW-1:0] start;
    logic [SkipW-1:0]  skip;
    logic [SizeW-1:0]  size_code;
    logic              mode2;
    logic              is_data;
  } entry_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic              raw;
    logic [FrameW-1:0] sector;
    logic [IdxW-1:0]   idx;
    entry_t            entry;
  } probe_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic red;
    logic fin;
  } step_t;

  typedef struct packed {
    status_e           status;
    logic [TrackW-1:0] track_number;
    logic              is_data;
    logic [SkipW-1:0]  byte_offset;
    logic [LenW-1:0]   read_length;
    logic [MinW-1:0]   abs_minute;
    logic [SecW-1:0]   abs_second;
    logic [FrmW-1:0]   abs_frame;
    logic [MinW-1:0]   rel_minute;
    logic [SecW-1:0]   rel_second;
    logic [FrmW-1:0]   rel_frame;
  } res_t;

  function automatic logic [LenW-1:0] size_bytes(logic [SizeW-1:0] code);
    logic [LenW-1:0] bytes;
    case (code)
      SizeMode2: bytes = Mode2Bytes;
      SizeRaw:   bytes = RawBytes;
      default:   bytes = CookedBytes;
    endcase
    return bytes;
  endfunction

endpackage

// ----- hw/rtl/cstl_if.sv -----
// Handshake channels of the sector track locator unit: input item,
// result item and configuration write. Depends on cstl_pkg.
interface cstl_in_if import cstl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [EntryIdxW-1:0] entry_index;
  logic [FrameW-1:0]    entry_start;
  logic [SkipW-1:0]     entry_skip;
  logic [SizeW-1:0]     entry_size_code;
  logic                 entry_mode2;
  logic                 entry_is_data;
  logic [FrameW-1:0]    sector;
  logic                 raw;

  modport source (
    output valid, action, entry_index, entry_start, entry_skip, entry_size_code,
           entry_mode2, entry_is_data, sector, raw,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_start, entry_skip, entry_size_code,
           entry_mode2, entry_is_data, sector, raw,
    output ready
  );
endinterface

interface cstl_out_if import cstl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [TrackW-1:0] track_number;
  logic              is_data;
  logic [SkipW-1:0]  byte_offset;
  logic [LenW-1:0]   read_length;
  logic [MinW-1:0]   abs_minute;
  logic [SecW-1:0]   abs_second;
  logic [FrmW-1:0]   abs_frame;
  logic [MinW-1:0]   rel_minute;
  logic [SecW-1:0]   rel_second;
  logic [FrmW-1:0]   rel_frame;

  modport source (
    output valid, status, track_number, is_data, byte_offset, read_length,
           abs_minute, abs_second, abs_frame, rel_minute, rel_second, rel_frame,
    input  ready
  );
  modport sink (
    input  valid, status, track_number, is_data, byte_offset, read_length,
           abs_minute, abs_second, abs_frame, rel_minute, rel_second, rel_frame,
    output ready
  );
endinterface

interface cstl_cfg_if import cstl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

// ----- hw/rtl/cstl_cell.sv -----
// One cell of the track chain: holds one table entry and tests the
// passing search token against its own and its successor's start.
// Depends on cstl_pkg.
module cstl_cell import cstl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW-1:0]      cell_idx_i,
  input  logic [CountW-1:0]    count_i,
  input  logic                 wr_i,
  input  logic [EntryIdxW-1:0] wr_idx_i,
  input  entry_t               wr_entry_i,
  input  logic [FrameW-1:0]    next_start_i,
  output logic [FrameW-1:0]    start_o,
  input  probe_t               probe_i,
  output probe_t               probe_o
);

  entry_t entry_q;
  probe_t pl_d, pl_q;
  logic   valid_q;
  logic   in_range;
  logic   hit;

  always_ff @(posedge clk_i) begin
    if (wr_i && (wr_idx_i == EntryIdxW'(cell_idx_i))) begin
      entry_q <= wr_entry_i;
    end
  end

  assign start_o = entry_q.start;

  // the lead-out entry is only a bound, never a track
  assign in_range = (CountW'(cell_idx_i) + CountW'(1)) < count_i;
  assign hit = probe_i.valid && !probe_i.found && in_range &&
               (entry_q.start <= probe_i.sector) && (probe_i.sector < next_start_i);

  always_comb begin
    pl_d = probe_i;
    if (hit) begin
      pl_d.found = 1'b1;
      pl_d.idx   = cell_idx_i;
      pl_d.entry = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
  end

  always_comb begin
    probe_o       = pl_q;
    probe_o.valid = valid_q;
  end

endmodule

// ----- hw/rtl/cstl_calc.sv -----
// Post-search arithmetic: byte offset with saturation and the two MSF
// conversions, over four sequenced steps. Depends on cstl_pkg.
module cstl_calc import cstl_pkg::*; (
  input  logic   clk_i,
  input  step_t  step_i,
  input  probe_t probe_i,
  output res_t   res_o
);

  logic              found_q, raw_q, mode2_q, data_q;
  logic [IdxW-1:0]   idx_q;
  logic [SizeW-1:0]  size_q;
  logic [SkipW-1:0]  skip_q;
  logic [FrameW-1:0] rel_q;
  logic [MsfW-1:0]   absp_q, relp_q;
  logic [QuotW-1:0]  qa_q, qr_q;
  logic [ProdW-1:0]  prod_q;
  logic [FrmW-1:0]   fa_q, fr_q;
  logic [MinW-1:0]   ma_q, mr_q;
  logic [SecW-1:0]   sa_q, sr_q;
  logic [SkipW-1:0]  off_q;

  logic [2*MsfW-1:0]  qa_prod, qr_prod;
  logic [2*QuotW:0]   ma_prod, mr_prod;
  logic [SumW-1:0]    adj, sum;

  assign qa_prod = (2*MsfW)'(absp_q) * (2*MsfW)'(Recip75);
  assign qr_prod = (2*MsfW)'(relp_q) * (2*MsfW)'(Recip75);
  assign ma_prod = (2*QuotW+1)'(qa_q) * (2*QuotW+1)'(Recip60);
  assign mr_prod = (2*QuotW+1)'(qr_q) * (2*QuotW+1)'(Recip60);

  always_comb begin
    adj = '0;
    if (!raw_q) begin
      if (mode2_q) begin
        adj = AdjMode2;
      end else if (size_q == SizeRaw) begin
        adj = AdjMode1;
      end
    end
  end

  assign sum = SumW'(skip_q) + SumW'(prod_q) + adj;

  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      found_q <= probe_i.found;
      raw_q   <= probe_i.raw;
      idx_q   <= probe_i.idx;
      mode2_q <= probe_i.entry.mode2;
      data_q  <= probe_i.entry.is_data;
      size_q  <= probe_i.entry.size_code;
      skip_q  <= probe_i.entry.skip;
      rel_q   <= probe_i.sector - probe_i.entry.start;
      relp_q  <= MsfW'(probe_i.sector - probe_i.entry.start) + MsfLead;
      absp_q  <= MsfW'(probe_i.sector) + MsfLead;
    end
    if (step_i.mul) begin
      qa_q   <= QuotW'(qa_prod >> Recip75Sh);
      qr_q   <= QuotW'(qr_prod >> Recip75Sh);
      prod_q <= ProdW'(rel_q) * ProdW'(size_bytes(size_q));
    end
    if (step_i.red) begin
      fa_q  <= FrmW'(absp_q - MsfW'(qa_q) * MsfW'(75));
      fr_q  <= FrmW'(relp_q - MsfW'(qr_q) * MsfW'(75));
      ma_q  <= MinW'(ma_prod >> Recip60Sh);
      mr_q  <= MinW'(mr_prod >> Recip60Sh);
      off_q <= sum[SumW-1] ? '1 : sum[SkipW-1:0];
    end
    if (step_i.fin) begin
      sa_q <= SecW'(qa_q - QuotW'(ma_q) * QuotW'(60));
      sr_q <= SecW'(qr_q - QuotW'(mr_q) * QuotW'(60));
    end
  end

  always_comb begin
    res_o = '0;
    if (!found_q) begin
      res_o.status = StNoTrack;
    end else begin
      res_o.track_number = TrackW'(idx_q) + TrackW'(1);
      res_o.is_data      = data_q;
      res_o.abs_minute   = ma_q;
      res_o.abs_second   = sa_q;
      res_o.abs_frame    = fa_q;
      res_o.rel_minute   = mr_q;
      res_o.rel_second   = sr_q;
      res_o.rel_frame    = fr_q;
      if (raw_q && (size_q != SizeRaw)) begin
        res_o.status = StRawErr;
      end else begin
        res_o.status      = StOk;
        res_o.byte_offset = off_q;
        res_o.read_length = raw_q ? RawBytes : CookedBytes;
      end
    end
  end

endmodule

// ----- hw/rtl/cd_sector_track_locator_unit.sv -----
// Top level of the sector track locator: cell chain, arithmetic steps,
// control and result register. Depends on cstl_pkg, cstl_if, cstl_cell,
// cstl_calc and cd_sector_track_locator_unit_assert.svh.
//
// Usage: cfg_i writes entry_count (loaded entries including lead-out);
// write it only while the unit is idle. in_i carries one item: a write
// item (action 0) loads one table slot, a lookup item (action 1) looks up
// a sector. out_o returns one result item per input item.
// A write item moves the unit from S_IDLE to S_DONE, and its all-zero result
// is then loaded into the output register. A lookup walks a token down a chain
// of MaxEntries cells, one cell per cycle, then three arithmetic steps follow
// (S_MUL, S_RED, S_FIN) before S_DONE loads its result. in_i.ready is high only
// between items, in S_IDLE, so the unit takes no new item until the last one
// has left S_DONE; the chain length sets how long a lookup occupies the unit.
// A finished result waits in the output register, so the next item is
// accepted while out_o stalls; a second result then holds in the unit
// until the first is taken. Reset clears entry_count and all control
// state; table contents are undefined until written.
`include "cd_sector_track_locator_unit_assert.svh"
module cd_sector_track_locator_unit import cstl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cstl_cfg_if.sink   cfg_i,
  cstl_in_if.sink    in_i,
  cstl_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MUL  = 6'b000100,
    S_RED  = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e            state_d, state_q;
  logic [CountW-1:0] count_q, count_n;
  logic              wr_item_d, wr_item_q;
  logic              out_valid_d, out_valid_q;
  res_t              out_d, out_q;
  res_t              calc_res;
  step_t             step;
  logic              accept, wr_en, out_load;
  entry_t            wr_entry;
  probe_t            probe_chain [MaxEntries+1];
  probe_t            chain_out;
  logic [FrameW-1:0] start_vec [MaxEntries];
  logic [MaxEntries-1:0] probe_vld;
  logic              past_leadout;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.entry_count;
    end
  end

  assign count_n = (count_q > CountW'(MaxEntries)) ? CountW'(MaxEntries) : count_q;

  // input side
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign wr_en      = accept && (in_i.action == ActWrite);

  assign wr_entry.start     = in_i.entry_start;
  assign wr_entry.skip      = in_i.entry_skip;
  assign wr_entry.size_code = in_i.entry_size_code;
  assign wr_entry.mode2     = in_i.entry_mode2;
  assign wr_entry.is_data   = in_i.entry_is_data;

  always_comb begin
    probe_chain[0]        = '0;
    probe_chain[0].valid  = accept && (in_i.action == ActLookup);
    probe_chain[0].sector = in_i.sector;
    probe_chain[0].raw    = in_i.raw;
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic [FrameW-1:0] nxt_start;
    if (g < MaxEntries - 1) begin : g_mid
      assign nxt_start = start_vec[g+1];
    end else begin : g_last
      assign nxt_start = '0;
    end
    cstl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (IdxW'(g)),
      .count_i      (count_n),
      .wr_i         (wr_en),
      .wr_idx_i     (in_i.entry_index),
      .wr_entry_i   (wr_entry),
      .next_start_i (nxt_start),
      .start_o      (start_vec[g]),
      .probe_i      (probe_chain[g]),
      .probe_o      (probe_chain[g+1])
    );
    assign probe_vld[g] = probe_chain[g+1].valid;
  end

  assign chain_out = probe_chain[MaxEntries];

  cstl_calc u_calc (
    .clk_i   (clk_i),
    .step_i  (step),
    .probe_i (chain_out),
    .res_o   (calc_res)
  );

  // sequencer
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    wr_item_d = wr_item_q;
    step      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          wr_item_d = (in_i.action == ActWrite);
          state_d   = (in_i.action == ActWrite) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain_out.valid) begin
          step.load = 1'b1;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        step.mul = 1'b1;
        state_d  = S_RED;
      end
      S_RED: begin
        step.red = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        step.fin = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_item_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_item_q   <= wr_item_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = wr_item_q ? '0 : calc_res;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.track_number = out_q.track_number;
  assign out_o.is_data      = out_q.is_data;
  assign out_o.byte_offset  = out_q.byte_offset;
  assign out_o.read_length  = out_q.read_length;
  assign out_o.abs_minute   = out_q.abs_minute;
  assign out_o.abs_second   = out_q.abs_second;
  assign out_o.abs_frame    = out_q.abs_frame;
  assign out_o.rel_minute   = out_q.rel_minute;
  assign out_o.rel_second   = out_q.rel_second;
  assign out_o.rel_frame    = out_q.rel_frame;

  // a hit on the lead-out entry or beyond it
  assign past_leadout = chain_out.valid && chain_out.found &&
                        ((CountW'(chain_out.idx) + CountW'(1)) >= count_n);

  `CSTL_ASSERT(a_exit_in_scan, chain_out.valid |-> state_q == S_SCAN)
  `CSTL_ASSERT(a_single_token, $onehot0(probe_vld))
  `CSTL_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `CSTL_NEVER(a_hit_past_leadout, past_leadout)

endmodule
